[rtl/core/agsm_pkg.sv]
// Shared types, widths and helpers for the atlas gutter source mapper.
package agsm_pkg;

    localparam int COORD_W  = 17;  // destination coordinate
    localparam int TILE_W   = 9;   // tile_size, tiles_across, tiles_down
    localparam int PAD_W    = 5;   // pad_pixels
    localparam int STRIDE_W = 10;  // tile_size + 2*pad_pixels
    localparam int LIM_W    = 19;  // tiles * stride
    localparam int QUO_W    = 9;   // tile index
    localparam int REM_W    = 10;  // offset inside one stride
    localparam int SRC_W    = 18;  // full-precision source coordinate
    localparam int OFF_W    = 34;  // byte offset
    localparam int OUT_XY_W = 16;
    localparam int IDX_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam int GUTTER_SIDES = 2;
    localparam int DIV_STEPS_PER_STAGE = 3;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS_PER_STAGE;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILE_SIZE    = 2'd0,
        CFG_PAD_PIXELS   = 2'd1,
        CFG_TILES_ACROSS = 2'd2,
        CFG_TILES_DOWN   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [TILE_W-1:0] tile_size;
        logic [PAD_W-1:0]  pad_pixels;
        logic [TILE_W-1:0] tiles_across;
        logic [TILE_W-1:0] tiles_down;
    } cfg_t;

    // one axis of the restoring divider: remainder, dividend bits still to
    // shift in (msb first) and quotient bits so far
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] pend;
        logic [QUO_W-1:0] quo;
    } div_axis_t;

    typedef struct packed {
        div_axis_t x;
        div_axis_t y;
        logic      oor;
    } div_t;

    typedef struct packed {
        logic [SRC_W-1:0] src_x;
        logic [SRC_W-1:0] src_y;
        logic [IDX_W-1:0] tile_col;
        logic [IDX_W-1:0] tile_row;
        logic             gutter;
        logic [SRC_W-1:0] src_width;
        logic             oor;
    } map_t;

    typedef struct packed {
        logic [OFF_W-1:0]    lin;
        logic [OUT_XY_W-1:0] src_x;
        logic [OUT_XY_W-1:0] src_y;
        logic [IDX_W-1:0]    tile_col;
        logic [IDX_W-1:0]    tile_row;
        logic                gutter;
        logic                oor;
    } lin_t;

    typedef struct packed {
        logic [OUT_XY_W-1:0] src_x;
        logic [OUT_XY_W-1:0] src_y;
        logic [IDX_W-1:0]    tile_col;
        logic [IDX_W-1:0]    tile_row;
        logic                is_gutter;
        logic [OFF_W-1:0]    byte_offset;
        logic                oor;
    } res_t;

    function automatic logic [STRIDE_W-1:0] stride_of(input cfg_t c);
        return STRIDE_W'(c.tile_size) + STRIDE_W'(GUTTER_SIDES) * STRIDE_W'(c.pad_pixels);
    endfunction

endpackage

[rtl/core/agsm_front.sv]
// Input stage: atlas bounds check and divider setup.
module agsm_front
    import agsm_pkg::*;
(
    input  logic               aclk,
    input  logic               load,
    input  cfg_t               cfg,
    input  logic [COORD_W-1:0] dest_x,
    input  logic [COORD_W-1:0] dest_y,
    output div_t               q
);

    logic [STRIDE_W-1:0] stride;
    logic [LIM_W-1:0]    lim_x;
    logic [LIM_W-1:0]    lim_y;
    div_t                q_next;
    div_t                q_reg;

    always_comb begin
        stride = stride_of(cfg);
        lim_x  = LIM_W'(cfg.tiles_across) * LIM_W'(stride);
        lim_y  = LIM_W'(cfg.tiles_down) * LIM_W'(stride);

        q_next.oor = (cfg.tile_size == '0) || (LIM_W'(dest_x) >= lim_x)
                     || (LIM_W'(dest_y) >= lim_y);
        // top bits start the remainder; in range they are already below stride
        q_next.x.rem  = REM_W'(dest_x[COORD_W-1:QUO_W]);
        q_next.x.pend = dest_x[QUO_W-1:0];
        q_next.x.quo  = '0;
        q_next.y.rem  = REM_W'(dest_y[COORD_W-1:QUO_W]);
        q_next.y.pend = dest_y[QUO_W-1:0];
        q_next.y.quo  = '0;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

[rtl/core/agsm_div_stage.sv]
// Three restoring-division steps per axis, coordinate divided by stride.
module agsm_div_stage
    import agsm_pkg::*;
(
    input  logic aclk,
    input  logic load,
    input  cfg_t cfg,
    input  div_t d,
    output div_t q
);

    div_t q_next;
    div_t q_reg;

    function automatic div_axis_t div_steps(input div_axis_t a, input logic [STRIDE_W-1:0] s);
        div_axis_t        r;
        logic [REM_W:0]   trial;
        r = a;
        for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
            trial  = {r.rem, r.pend[QUO_W-1]};
            r.pend = r.pend << 1;
            if (trial >= (REM_W+1)'(s)) begin
                r.rem = REM_W'(trial - (REM_W+1)'(s));
                r.quo = {r.quo[QUO_W-2:0], 1'b1};
            end else begin
                r.rem = trial[REM_W-1:0];
                r.quo = {r.quo[QUO_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    always_comb begin
        q_next.x   = div_steps(d.x, stride_of(cfg));
        q_next.y   = div_steps(d.y, stride_of(cfg));
        q_next.oor = d.oor;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

[rtl/core/agsm_map.sv]
// Gutter clamp and source coordinate per axis.
module agsm_map
    import agsm_pkg::*;
(
    input  logic aclk,
    input  logic load,
    input  cfg_t cfg,
    input  div_t d,
    output map_t q
);

    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic             gutter;
    } axis_t;

    axis_t ax;
    axis_t ay;
    map_t  q_next;
    map_t  q_reg;

    function automatic axis_t map_axis(input logic [REM_W-1:0] off,
                                       input logic [QUO_W-1:0] tile_idx,
                                       input cfg_t c);
        axis_t             r;
        logic [REM_W-1:0]  inner;
        logic [TILE_W-1:0] loc;
        inner    = off - REM_W'(c.pad_pixels);
        r.gutter = 1'b1;
        if (off < REM_W'(c.pad_pixels)) begin
            loc = '0;
        end else if (inner >= REM_W'(c.tile_size)) begin
            loc = c.tile_size - TILE_W'(1);
        end else begin
            loc      = inner[TILE_W-1:0];
            r.gutter = 1'b0;
        end
        r.src = SRC_W'(tile_idx) * SRC_W'(c.tile_size) + SRC_W'(loc);
        return r;
    endfunction

    always_comb begin
        ax = map_axis(d.x.rem, d.x.quo, cfg);
        ay = map_axis(d.y.rem, d.y.quo, cfg);
        q_next.src_x     = ax.src;
        q_next.src_y     = ay.src;
        q_next.tile_col  = d.x.quo[IDX_W-1:0];
        q_next.tile_row  = d.y.quo[IDX_W-1:0];
        q_next.gutter    = ax.gutter | ay.gutter;
        q_next.src_width = SRC_W'(cfg.tiles_across) * SRC_W'(cfg.tile_size);
        q_next.oor       = d.oor;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

[rtl/core/agsm_lin.sv]
// Linear source pixel index: row * width + column.
module agsm_lin
    import agsm_pkg::*;
(
    input  logic aclk,
    input  logic load,
    input  map_t d,
    output lin_t q
);

    localparam int PROD_W = 2 * SRC_W + 1;

    logic [PROD_W-1:0] prod;
    lin_t              q_next;
    lin_t              q_reg;

    always_comb begin
        prod = PROD_W'(d.src_y) * PROD_W'(d.src_width) + PROD_W'(d.src_x);
        q_next.lin      = prod[OFF_W-1:0];
        q_next.src_x    = d.src_x[OUT_XY_W-1:0];
        q_next.src_y    = d.src_y[OUT_XY_W-1:0];
        q_next.tile_col = d.tile_col;
        q_next.tile_row = d.tile_row;
        q_next.gutter   = d.gutter;
        q_next.oor      = d.oor;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

[rtl/core/agsm_out.sv]
// Output register: byte scaling and zeroing of out-of-range results.
module agsm_out
    import agsm_pkg::*;
#(
    parameter int BYTES_PER_PIXEL = 4
) (
    input  logic aclk,
    input  logic load,
    input  lin_t d,
    output res_t q
);

    localparam int BPP_W = $clog2(BYTES_PER_PIXEL + 1);
    localparam logic [BPP_W-1:0] BPP = BPP_W'(BYTES_PER_PIXEL);

    logic [OFF_W+BPP_W-1:0] scaled;
    res_t                   q_next;
    res_t                   q_reg;

    always_comb begin
        scaled = (OFF_W+BPP_W)'(d.lin) * (OFF_W+BPP_W)'(BPP);
        q_next = '0;
        q_next.oor = d.oor;
        if (!d.oor) begin
            q_next.src_x       = d.src_x;
            q_next.src_y       = d.src_y;
            q_next.tile_col    = d.tile_col;
            q_next.tile_row    = d.tile_row;
            q_next.is_gutter   = d.gutter;
            q_next.byte_offset = scaled[OFF_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

[rtl/core/atlas_gutter_source_mapper.sv]
// Top level: config registers, stage control and stream ports.
//
// Maps a destination pixel of a padded tile atlas to the source pixel that
// the gutter copy places there, with its tile indices, gutter flag and byte
// offset. One beat is accepted per clock while m_tready stays high; each
// beat passes a bounds stage, then the stride divider, a nine-step restoring
// divider spread three steps per stage over three stages, then a
// clamp/multiply stage, a row*width stage and the output register. When the
// output stalls the stages fill up and s_tready drops once all are full.
// Config writes must only happen while no beat is in flight.
module atlas_gutter_source_mapper
    import agsm_pkg::*;
#(
    parameter int BYTES_PER_PIXEL = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // dest_x[16:0], dest_y[33:17], zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [87:0]           m_tdata,   // src_x[15:0], src_y[31:16],
                                             // tile_col[39:32], tile_row[47:40],
                                             // src_byte_offset[81:48], zero
    output logic [1:0]            m_tuser    // is_gutter[0], out_of_range[1]
);

    localparam int NSTAGE = DIV_STAGES + 4;

    cfg_t              cfg_reg;
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] adv;

    div_t div_q [DIV_STAGES+1];
    map_t map_q;
    lin_t lin_q;
    res_t res_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tile_size    <= TILE_W'(16);
            cfg_reg.pad_pixels   <= PAD_W'(2);
            cfg_reg.tiles_across <= TILE_W'(16);
            cfg_reg.tiles_down   <= TILE_W'(16);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_TILE_SIZE:    cfg_reg.tile_size    <= cfg_wdata;
                CFG_PAD_PIXELS:   cfg_reg.pad_pixels   <= cfg_wdata[PAD_W-1:0];
                CFG_TILES_ACROSS: cfg_reg.tiles_across <= cfg_wdata;
                CFG_TILES_DOWN:   cfg_reg.tiles_down   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its contents move on
    always_comb begin
        adv[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next = valid_reg;
        if (adv[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int i = 1; i < NSTAGE; i++) begin
            if (adv[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // no beat is taken while reset is held
    assign s_tready = aresetn && adv[0];

    agsm_front u_front (
        .aclk   (aclk),
        .load   (adv[0]),
        .cfg    (cfg_reg),
        .dest_x (s_tdata[COORD_W-1:0]),
        .dest_y (s_tdata[2*COORD_W-1:COORD_W]),
        .q      (div_q[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        agsm_div_stage u_div (
            .aclk (aclk),
            .load (adv[g+1]),
            .cfg  (cfg_reg),
            .d    (div_q[g]),
            .q    (div_q[g+1])
        );
    end

    agsm_map u_map (
        .aclk (aclk),
        .load (adv[DIV_STAGES+1]),
        .cfg  (cfg_reg),
        .d    (div_q[DIV_STAGES]),
        .q    (map_q)
    );

    agsm_lin u_lin (
        .aclk (aclk),
        .load (adv[DIV_STAGES+2]),
        .d    (map_q),
        .q    (lin_q)
    );

    agsm_out #(
        .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
    ) u_out (
        .aclk (aclk),
        .load (adv[DIV_STAGES+3]),
        .d    (lin_q),
        .q    (res_q)
    );

    assign m_tvalid = valid_reg[NSTAGE-1];
    assign m_tdata  = {6'b0, res_q.byte_offset, res_q.tile_row, res_q.tile_col,
                       res_q.src_y, res_q.src_x};
    assign m_tuser  = {res_q.oor, res_q.is_gutter};

endmodule
